FILE: rtl/akr_pkg.sv
package akr_pkg;

    localparam int TIME_BITS   = 48;
    localparam int NUM_AXES    = 6;
    localparam int NUM_ENTRIES = 10;
    localparam int ENTRY_BITS  = 4;
    localparam int AXIS_BITS   = 3;
    localparam int LEVEL_BITS  = 16;
    localparam int KEY_BITS    = 3;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_BITS = 2;
    localparam int INQ_DEPTH     = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_STICK_PRESS   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STICK_RELEASE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_PRESS    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_RELEASE  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_DELAY  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REPEAT_PERIOD = 3'd5;

    localparam logic [CFG_BITS-1:0] RST_STICK_PRESS   = 16'd16000;
    localparam logic [CFG_BITS-1:0] RST_STICK_RELEASE = 16'd9000;
    localparam logic [CFG_BITS-1:0] RST_TRIG_PRESS    = 16'd20000;
    localparam logic [CFG_BITS-1:0] RST_TRIG_RELEASE  = 16'd8000;
    localparam logic [CFG_BITS-1:0] RST_REPEAT_DELAY  = 16'd400;
    localparam logic [CFG_BITS-1:0] RST_REPEAT_PERIOD = 16'd140;

    localparam logic [KEY_BITS-1:0] KEY_LEFT  = 3'd0;
    localparam logic [KEY_BITS-1:0] KEY_RIGHT = 3'd1;
    localparam logic [KEY_BITS-1:0] KEY_UP    = 3'd2;
    localparam logic [KEY_BITS-1:0] KEY_DOWN  = 3'd3;
    localparam logic [KEY_BITS-1:0] KEY_PRIOR = 3'd4;
    localparam logic [KEY_BITS-1:0] KEY_NEXT  = 3'd5;

    typedef struct packed {
        logic [CFG_BITS-1:0] stick_press;
        logic [CFG_BITS-1:0] stick_release;
        logic [CFG_BITS-1:0] trig_press;
        logic [CFG_BITS-1:0] trig_release;
        logic [CFG_BITS-1:0] repeat_delay;
        logic [CFG_BITS-1:0] repeat_period;
    } cfg_t;

    typedef struct packed {
        logic                         is_tick;
        logic [AXIS_BITS-1:0]         axis;
        logic signed [LEVEL_BITS-1:0] level;
        logic [TIME_BITS-1:0]         time_ms;
    } op_t;

    typedef struct packed {
        logic [ENTRY_BITS-1:0] entry_index;
        logic [KEY_BITS-1:0]   key_code;
        logic                  is_release;
        logic                  last_of_run;
    } result_t;

    typedef struct packed {
        logic [AXIS_BITS-1:0] axis;
        logic                 negative;
        logic [KEY_BITS-1:0]  key;
        logic                 trigger;
    } entry_def_t;

    function automatic entry_def_t entry_def(input logic [ENTRY_BITS-1:0] idx);
        entry_def_t d;
        unique case (idx)
            4'd0:    d = '{axis: 3'd0, negative: 1'b1, key: KEY_LEFT,  trigger: 1'b0};
            4'd1:    d = '{axis: 3'd0, negative: 1'b0, key: KEY_RIGHT, trigger: 1'b0};
            4'd2:    d = '{axis: 3'd1, negative: 1'b1, key: KEY_UP,    trigger: 1'b0};
            4'd3:    d = '{axis: 3'd1, negative: 1'b0, key: KEY_DOWN,  trigger: 1'b0};
            4'd4:    d = '{axis: 3'd2, negative: 1'b1, key: KEY_LEFT,  trigger: 1'b0};
            4'd5:    d = '{axis: 3'd2, negative: 1'b0, key: KEY_RIGHT, trigger: 1'b0};
            4'd6:    d = '{axis: 3'd3, negative: 1'b1, key: KEY_UP,    trigger: 1'b0};
            4'd7:    d = '{axis: 3'd3, negative: 1'b0, key: KEY_DOWN,  trigger: 1'b0};
            4'd8:    d = '{axis: 3'd4, negative: 1'b0, key: KEY_PRIOR, trigger: 1'b1};
            4'd9:    d = '{axis: 3'd5, negative: 1'b0, key: KEY_NEXT,  trigger: 1'b1};
            default: d = '{axis: 3'd0, negative: 1'b0, key: KEY_LEFT,  trigger: 1'b0};
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/akr_front.sv
module akr_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  cmd,
    input  logic [akr_pkg::AXIS_BITS-1:0]         axis_number,
    input  logic signed [akr_pkg::LEVEL_BITS-1:0] axis_level,
    input  logic [akr_pkg::TIME_BITS-1:0]         time_ms,
    output logic                                  op_valid,
    output akr_pkg::op_t                          op,
    input  logic                                  op_take
);
    import akr_pkg::*;

    op_t        q_reg [INQ_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       keep;
    logic       enq;
    logic       deq;

    assign full     = (count_reg == 2'(INQ_DEPTH));
    assign accept   = push && !full;
    // updates to axes beyond the last are dropped here
    assign keep     = cmd || (axis_number < AXIS_BITS'(NUM_AXES));
    assign enq      = accept && keep;
    assign op_valid = (count_reg != 2'd0);
    assign deq      = op_valid && op_take;
    assign op       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= '{is_tick: cmd, axis: axis_number,
                                   level: axis_level, time_ms: time_ms};
        end
    end

endmodule

FILE: rtl/akr_outq.sv
module akr_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  akr_pkg::result_t wr_data,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output akr_pkg::result_t rd_data
);
    import akr_pkg::*;

    result_t                  mem_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_PTR_BITS:0]   count_reg, count_next;
    logic                     enq;
    logic                     deq;

    assign full    = (count_reg == (OUTQ_PTR_BITS+1)'(OUTQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign enq     = wr_en && !full;
    assign deq     = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/akr_scan.sv
module akr_scan (
    input  logic             clk,
    input  logic             rst_n,
    input  akr_pkg::cfg_t    cfg,
    input  logic             op_valid,
    input  akr_pkg::op_t     op,
    output logic             op_take,
    input  logic             outq_full,
    output logic             res_push,
    output akr_pkg::result_t res
);
    import akr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [ENTRY_BITS-1:0]        idx_reg, idx_next;
    logic [TIME_BITS-1:0]         now_reg, now_next;
    logic signed [LEVEL_BITS-1:0] axis_reg [NUM_AXES];
    logic signed [LEVEL_BITS-1:0] axis_next [NUM_AXES];
    logic [NUM_ENTRIES-1:0]       held_reg, held_next;
    logic [TIME_BITS-1:0]         fire_reg [NUM_ENTRIES];
    logic [TIME_BITS-1:0]         fire_next [NUM_ENTRIES];
    logic                         pend_valid_reg, pend_valid_next;
    result_t                      pend_reg, pend_next;

    entry_def_t                   def;
    logic signed [LEVEL_BITS-1:0] lvl;
    logic signed [LEVEL_BITS+1:0] defl;
    logic signed [LEVEL_BITS+1:0] press_w;
    logic signed [LEVEL_BITS+1:0] release_w;
    logic [CFG_BITS-1:0]          step_ms;
    logic [TIME_BITS-1:0]         sum_ms;
    logic                         due;
    logic                         advance;
    logic                         fired;
    logic                         rel;
    logic                         last_idx;

    assign def      = entry_def(idx_reg);
    assign lvl      = axis_reg[def.axis];
    // negating the most negative level gives +32768, hence the extra bits
    assign defl     = def.negative ? -(LEVEL_BITS+2)'(lvl) : (LEVEL_BITS+2)'(lvl);
    assign press_w  = signed'({2'b00, def.trigger ? cfg.trig_press : cfg.stick_press});
    assign release_w = signed'({2'b00, def.trigger ? cfg.trig_release : cfg.stick_release});
    assign step_ms  = held_reg[idx_reg] ? cfg.repeat_period : cfg.repeat_delay;
    assign sum_ms   = now_reg + TIME_BITS'(step_ms);
    assign due      = (now_reg >= fire_reg[idx_reg]);
    assign advance  = (state_reg == ST_SCAN) && !outq_full;
    assign last_idx = (idx_reg == ENTRY_BITS'(NUM_ENTRIES - 1));
    assign op_take  = (state_reg == ST_IDLE) && op_valid;

    always_comb
    begin
        fired = 1'b0;
        rel   = 1'b0;
        if (!held_reg[idx_reg])
        begin
            fired = (defl >= press_w);
        end
        else if (defl <= release_w)
        begin
            fired = 1'b1;
            rel   = 1'b1;
        end
        else if (!def.trigger && due)
        begin
            fired = 1'b1;
        end
    end

    assign res_push = (advance && fired && pend_valid_reg)
                   || ((state_reg == ST_FLUSH) && pend_valid_reg && !outq_full);

    always_comb
    begin
        res             = pend_reg;
        res.last_of_run = (state_reg == ST_FLUSH);
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        axis_next       = axis_reg;
        held_next       = held_reg;
        fire_next       = fire_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_valid)
                begin
                    if (op.is_tick)
                    begin
                        now_next   = op.time_ms;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        axis_next[op.axis] = op.level;
                    end
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (fired)
                    begin
                        held_next[idx_reg] = !rel;
                        if (!rel)
                        begin
                            fire_next[idx_reg] = sum_ms;
                        end
                        pend_valid_next = 1'b1;
                        pend_next = '{entry_index: idx_reg, key_code: def.key,
                                      is_release: rel, last_of_run: 1'b0};
                    end
                    if (last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!outq_full)
                begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            held_reg       <= '0;
            pend_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                axis_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                fire_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            held_reg       <= held_next;
            pend_valid_reg <= pend_valid_next;
            axis_reg       <= axis_next;
            fire_reg       <= fire_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        pend_reg <= pend_next;
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg < ENTRY_BITS'(NUM_ENTRIES)))
        else $error("scan index beyond last entry");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending item left over after a tick");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !outq_full)
        else $error("item pushed into a full result queue");

    a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FLUSH) && !outq_full) |=> (state_reg == ST_IDLE))
        else $error("closing step did not return to idle");

endmodule

FILE: rtl/analog_axis_key_repeater_top.sv
// Analog axis to key event repeater.
// Input channel (push/full): cmd 0 stores axis_level for axis_number 0..5
// (other axis numbers are taken and dropped); cmd 1 is a frame tick that
// scans the ten axis-half entries at time_ms.
// Result channel (empty/pop): one item per key event in entry order, the
// final one of a tick flagged by last_of_run. A tick that fires nothing
// gives no item.
// Input items pass a two-item queue into the scanner. The scanner takes an
// update in its idle state; a tick is taken, then scans one entry per cycle
// while the result queue has room, then passes a closing step. A result is
// handed on when the next entry fires or at the closing step. The four-item
// result queue lets the scanner run ahead of the receiver; when it fills the
// scanner stalls, then the input queue fills and full rises. No item is lost
// while pop is held low.
// Reset clears both queues, all axis levels, held flags and repeat times,
// and loads the register defaults. The user must write registers via cfg_we,
// cfg_addr and cfg_wdata only while the block is idle; the block does not check.
module analog_axis_key_repeater_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  cmd,
    input  logic [akr_pkg::AXIS_BITS-1:0]         axis_number,
    input  logic signed [akr_pkg::LEVEL_BITS-1:0] axis_level,
    input  logic [akr_pkg::TIME_BITS-1:0]         time_ms,
    input  logic                                  cfg_we,
    input  logic [akr_pkg::CFG_IDX_BITS-1:0]      cfg_addr,
    input  logic [akr_pkg::CFG_BITS-1:0]          cfg_wdata,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [akr_pkg::ENTRY_BITS-1:0]        entry_index,
    output logic [akr_pkg::KEY_BITS-1:0]          key_code,
    output logic                                  is_release,
    output logic                                  last_of_run
);
    import akr_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    op_valid;
    op_t     op;
    logic    op_take;
    logic    outq_full;
    logic    res_push;
    result_t res;
    result_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_STICK_PRESS:   cfg_next.stick_press   = cfg_wdata;
                CFG_STICK_RELEASE: cfg_next.stick_release = cfg_wdata;
                CFG_TRIG_PRESS:    cfg_next.trig_press    = cfg_wdata;
                CFG_TRIG_RELEASE:  cfg_next.trig_release  = cfg_wdata;
                CFG_REPEAT_DELAY:  cfg_next.repeat_delay  = cfg_wdata;
                CFG_REPEAT_PERIOD: cfg_next.repeat_period = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{stick_press:   RST_STICK_PRESS,
                         stick_release: RST_STICK_RELEASE,
                         trig_press:    RST_TRIG_PRESS,
                         trig_release:  RST_TRIG_RELEASE,
                         repeat_delay:  RST_REPEAT_DELAY,
                         repeat_period: RST_REPEAT_PERIOD};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    akr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .axis_number (axis_number),
        .axis_level  (axis_level),
        .time_ms     (time_ms),
        .op_valid    (op_valid),
        .op          (op),
        .op_take     (op_take)
    );

    akr_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take),
        .outq_full (outq_full),
        .res_push  (res_push),
        .res       (res)
    );

    akr_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .full    (outq_full),
        .empty   (empty),
        .pop     (pop),
        .rd_data (head)
    );

    assign entry_index = head.entry_index;
    assign key_code    = head.key_code;
    assign is_release  = head.is_release;
    assign last_of_run = head.last_of_run;

endmodule

FILE: dv/tb_analog_axis_key_repeater_top.sv
module tb_analog_axis_key_repeater_top;
    timeunit 1ns;
    timeprecision 1ps;

    import akr_pkg::*;

    localparam bit CMD_UPDATE = 1'b0;
    localparam bit CMD_TICK   = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    localparam int NUM_REGS           = 6;
    localparam int NUM_STICKS         = 8;
    localparam int FIRST_TRIGGER_AXIS = 4;
    localparam int USE_PREDICTOR      = -1;
    localparam int MAX_GAP            = 13;
    localparam int SETTLE_CYCLES      = 48;
    localparam int CYCLE_LIMIT        = 300000;

    localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

    typedef struct {
        bit                           c;
        logic [AXIS_BITS-1:0]         ax;
        logic signed [LEVEL_BITS-1:0] lv;
        logic [TIME_BITS-1:0]         t;
        int                           n_typed;
        logic [ENTRY_BITS-1:0]        ent;
        logic [KEY_BITS-1:0]          key;
        bit                           rel;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n       = 1'b0;
    logic                         push        = 1'b0;
    logic                         full;
    logic                         cmd         = 1'b0;
    logic [AXIS_BITS-1:0]         axis_number = '0;
    logic signed [LEVEL_BITS-1:0] axis_level  = '0;
    logic [TIME_BITS-1:0]         time_ms     = '0;
    logic                         cfg_we      = 1'b0;
    logic [CFG_IDX_BITS-1:0]      cfg_addr    = '0;
    logic [CFG_BITS-1:0]          cfg_wdata   = '0;
    logic                         empty;
    logic                         pop         = 1'b0;
    logic [ENTRY_BITS-1:0]        entry_index;
    logic [KEY_BITS-1:0]          key_code;
    logic                         is_release;
    logic                         last_of_run;

    logic [CFG_BITS-1:0]          model_regs   [NUM_REGS];
    logic signed [LEVEL_BITS-1:0] model_levels [NUM_AXES];
    bit                           model_held   [NUM_ENTRIES];
    logic [TIME_BITS-1:0]         model_next   [NUM_ENTRIES];

    result_t              key_events [$];
    stim_row_t            plan [$];
    int                   n_bad       = 0;
    int                   n_predicted = 0;
    int                   cycles      = 0;
    bit                   no_idle     = 1'b0;
    logic [TIME_BITS-1:0] now_ms      = '0;

    analog_axis_key_repeater_top DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom(), $urandom()});
    endfunction

    // one frame tick scans entries 0..9 in order; updates only store a level
    function automatic void predict_key_events(input bit c,
                                               input logic [AXIS_BITS-1:0] ax,
                                               input logic signed [LEVEL_BITS-1:0] lv,
                                               input logic [TIME_BITS-1:0] t);
        int      first;
        int      defl;
        int      on_lvl;
        int      off_lvl;
        bit      trig;
        bit      fired;
        result_t ev;
        first = key_events.size();
        if (c == CMD_UPDATE)
        begin
            if (int'(ax) < NUM_AXES)
                model_levels[ax] = lv;
            return;
        end
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            trig    = (i >= NUM_STICKS);
            defl    = int'(model_levels[trig ? i - 4 : i / 2]);
            if (!trig && (i % 2 == 0))
                defl = -defl;
            on_lvl  = trig ? int'(model_regs[CFG_TRIG_PRESS])
                           : int'(model_regs[CFG_STICK_PRESS]);
            off_lvl = trig ? int'(model_regs[CFG_TRIG_RELEASE])
                           : int'(model_regs[CFG_STICK_RELEASE]);
            fired   = 1'b0;
            ev.is_release = 1'b0;
            if (!model_held[i])
            begin
                if (defl >= on_lvl)
                begin
                    model_held[i] = 1'b1;
                    model_next[i] = t + TIME_BITS'(model_regs[CFG_REPEAT_DELAY]);
                    fired = 1'b1;
                end
            end
            else if (defl <= off_lvl)
            begin
                model_held[i] = 1'b0;
                fired = 1'b1;
                ev.is_release = 1'b1;
            end
            else if (!trig && t >= model_next[i])
            begin
                model_next[i] = t + TIME_BITS'(model_regs[CFG_REPEAT_PERIOD]);
                fired = 1'b1;
            end
            if (fired)
            begin
                ev.entry_index = ENTRY_BITS'(i);
                ev.last_of_run = 1'b0;
                if (trig)
                    ev.key_code = (i == NUM_STICKS) ? KEY_PRIOR : KEY_NEXT;
                else
                begin
                    case (i % 4)
                        0:       ev.key_code = KEY_LEFT;
                        1:       ev.key_code = KEY_RIGHT;
                        2:       ev.key_code = KEY_UP;
                        default: ev.key_code = KEY_DOWN;
                    endcase
                end
                key_events.push_back(ev);
            end
        end
        if (key_events.size() > first)
        begin
            ev = key_events.pop_back();
            ev.last_of_run = 1'b1;
            key_events.push_back(ev);
        end
        n_predicted += key_events.size() - first;
    endfunction

    function automatic logic signed [LEVEL_BITS-1:0] pick_level(input bit trig);
        int v;
        int on_lvl;
        int off_lvl;
        on_lvl  = trig ? int'(model_regs[CFG_TRIG_PRESS]) : int'(model_regs[CFG_STICK_PRESS]);
        off_lvl = trig ? int'(model_regs[CFG_TRIG_RELEASE])
                       : int'(model_regs[CFG_STICK_RELEASE]);
        case ($urandom_range(0, 7))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = 0;
            3:       v = on_lvl + $urandom_range(0, 6) - 3;
            4:       v = off_lvl + $urandom_range(0, 6) - 3;
            default: v = $urandom_range(0, 65535) - 32768;
        endcase
        if (!trig && $urandom_range(0, 1) == 1)
            v = -v;
        return LEVEL_BITS'(v);
    endfunction

    task automatic send_item(input bit c, input logic [AXIS_BITS-1:0] ax,
                             input logic signed [LEVEL_BITS-1:0] lv,
                             input logic [TIME_BITS-1:0] t,
                             input int n_typed = USE_PREDICTOR,
                             input logic [ENTRY_BITS-1:0] ent = '0,
                             input logic [KEY_BITS-1:0] key = KEY_LEFT,
                             input bit rel = 1'b0);
        int      gap;
        int      base;
        result_t typed;
        gap = draw_gap();
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        cmd         <= c;
        axis_number <= ax;
        axis_level  <= lv;
        time_ms     <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        base = key_events.size();
        predict_key_events(c, ax, lv, t);
        if (n_typed != USE_PREDICTOR)
        begin
            while (key_events.size() > base)
                void'(key_events.pop_back());
            if (n_typed == 1)
            begin
                typed = '{entry_index: ent, key_code: key, is_release: rel, last_of_run: 1'b1};
                key_events.push_back(typed);
            end
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        while (key_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (int'(idx) < NUM_REGS)
            model_regs[idx] = val;
    endtask

    task automatic load_settings(input logic [CFG_BITS-1:0] sp, input logic [CFG_BITS-1:0] sr,
                                 input logic [CFG_BITS-1:0] tp, input logic [CFG_BITS-1:0] tr,
                                 input logic [CFG_BITS-1:0] dly, input logic [CFG_BITS-1:0] per);
        write_reg(CFG_STICK_PRESS, sp);
        write_reg(CFG_STICK_RELEASE, sr);
        write_reg(CFG_TRIG_PRESS, tp);
        write_reg(CFG_TRIG_RELEASE, tr);
        write_reg(CFG_REPEAT_DELAY, dly);
        write_reg(CFG_REPEAT_PERIOD, per);
        write_reg(CFG_SPARE_LO, CFG_BITS'($urandom));
        write_reg(CFG_SPARE_HI, CFG_BITS'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // level changes and ticks, mostly at rising time, plus noise
    task automatic run_random(input int n, input int want_events);
        int                   sent;
        int                   pick;
        int                   goal;
        logic [AXIS_BITS-1:0] ax;
        sent = 0;
        goal = n_predicted + want_events;
        while ((sent < n || n_predicted < goal) && sent < n + 20)
        begin
            if ($urandom_range(0, 19) == 0)
                no_idle = !no_idle;
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                ax = AXIS_BITS'($urandom_range(NUM_AXES, 7));
                send_item(CMD_UPDATE, ax, LEVEL_BITS'($urandom), rand_time());
            end
            else if (pick < 45)
            begin
                ax = AXIS_BITS'($urandom_range(0, NUM_AXES - 1));
                send_item(CMD_UPDATE, ax, pick_level(int'(ax) >= FIRST_TRIGGER_AXIS),
                          rand_time());
                sent++;
            end
            else
            begin
                if (pick < 52)
                    now_ms = rand_time();
                else if ($urandom_range(0, 9) == 0)
                    now_ms += TIME_BITS'($urandom_range(0, 70000));
                else
                    now_ms += TIME_BITS'($urandom_range(0, 600));
                send_item(CMD_TICK, AXIS_BITS'($urandom), LEVEL_BITS'($urandom), now_ms);
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
                settle();
        end
    endtask

    function automatic void check_field(input string name, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_bad++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (key_events.size() == 0)
            begin
                $error("unexpected item: entry_index %0d key_code %0d is_release %0d",
                       entry_index, key_code, is_release);
                n_bad++;
            end
            else
            begin
                want = key_events.pop_front();
                check_field("entry_index", 4'(want.entry_index), 4'(entry_index));
                check_field("key_code", 4'(want.key_code), 4'(key_code));
                check_field("is_release", 4'(want.is_release), 4'(is_release));
                check_field("last_of_run", 4'(want.last_of_run), 4'(last_of_run));
            end
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
        end
    end

    initial
    begin
        model_regs[CFG_STICK_PRESS]   = RST_STICK_PRESS;
        model_regs[CFG_STICK_RELEASE] = RST_STICK_RELEASE;
        model_regs[CFG_TRIG_PRESS]    = RST_TRIG_PRESS;
        model_regs[CFG_TRIG_RELEASE]  = RST_TRIG_RELEASE;
        model_regs[CFG_REPEAT_DELAY]  = RST_REPEAT_DELAY;
        model_regs[CFG_REPEAT_PERIOD] = RST_REPEAT_PERIOD;
        foreach (model_levels[a])
            model_levels[a] = '0;
        foreach (model_held[e])
        begin
            model_held[e] = 1'b0;
            model_next[e] = '0;
        end

        // quiet tick after reset, most negative level, exact thresholds,
        // ignored axes, unused fields, and a repeat time wrapping past zero
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd0,        0, 4'd0, KEY_LEFT,  1'b0});
        plan.push_back('{CMD_UPDATE, 3'd0, -16'sd32768, TIME_TOP,    USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd7, 16'sh7FFF,  48'd100,      1, 4'd0, KEY_LEFT,  1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd499,      0, 4'd0, KEY_LEFT,  1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd500,      1, 4'd0, KEY_LEFT,  1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd639,      0, 4'd0, KEY_LEFT,  1'b0});
        plan.push_back('{CMD_UPDATE, 3'd0, 16'sd32767, 48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd700,      USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd1, 16'sd16000, 48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd4, 16'sd32767, 48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd5, 16'sd20000, 48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd6, 16'sd32767, 48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd7, -16'sd32768, 48'd0,       USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd1100,     USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd1, 16'sd9000,  48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd4, 16'sd8000,  48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd1200,     USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd5, -16'sd32768, 48'd0,       USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     TIME_TOP - 10, USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     TIME_TOP - 5, 1, 4'd1, KEY_RIGHT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd2, -16'sd32768, 48'd0,       USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_UPDATE, 3'd3, 16'sd32767, 48'd0,        USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     TIME_TOP,     USE_PREDICTOR, 4'd0, KEY_LEFT, 1'b0});
        plan.push_back('{CMD_TICK,   3'd0, 16'sd0,     48'd0,        0, 4'd0, KEY_LEFT,  1'b0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
            send_item(plan[k].c, plan[k].ax, plan[k].lv, plan[k].t,
                      plan[k].n_typed, plan[k].ent, plan[k].key, plan[k].rel);
        now_ms = '0;
        settle();

        load_settings(CFG_BITS'($urandom_range(4000, 30000)), CFG_BITS'($urandom_range(0, 4000)),
                      CFG_BITS'($urandom_range(4000, 32767)), CFG_BITS'($urandom_range(0, 4000)),
                      CFG_BITS'($urandom_range(0, 600)), CFG_BITS'($urandom_range(1, 300)));
        run_random(30, 0);
        settle();

        load_settings('0, '0, '0, '0, '0, '0);
        run_random(20, 0);
        settle();

        load_settings(16'd32768, 16'd32768, 16'd32768, 16'd32768, '1, '1);
        run_random(15, 0);
        settle();

        load_settings(CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom),
                      CFG_BITS'($urandom), CFG_BITS'($urandom), CFG_BITS'($urandom));
        run_random(20, 0);
        settle();

        load_settings(RST_STICK_PRESS, RST_STICK_RELEASE, RST_TRIG_PRESS, RST_TRIG_RELEASE,
                      RST_REPEAT_DELAY, RST_REPEAT_PERIOD);
        no_idle = 1'b0;
        run_random(25, 40);
        settle();

        if (n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
